// ===== design/samseq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// samseq_pkg: shared types and constants
// Phase codes, event codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package samseq_pkg;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_PRELOAD = 5'b00010,
        PH_START   = 5'b00100,
        PH_RUN     = 5'b01000,
        PH_STOP    = 5'b10000
    } t_phase;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_MOVE  = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ARRIVED   = 3'd1;
    localparam logic [2:0] EV_SETTLED   = 3'd2;
    localparam logic [2:0] EV_STOP_TO   = 3'd3;
    localparam logic [2:0] EV_FAULT     = 3'd4;
    localparam logic [2:0] EV_MOVE_TO   = 3'd5;
    localparam logic [2:0] EV_REJECTED  = 3'd6;

    localparam logic [2:0] REG_BAND     = 3'd0;
    localparam logic [2:0] REG_STILL    = 3'd1;
    localparam logic [2:0] REG_NSPEED   = 3'd2;
    localparam logic [2:0] REG_SNEED    = 3'd3;
    localparam logic [2:0] REG_STOP_TO  = 3'd4;
    localparam logic [2:0] REG_MOVE_TO  = 3'd5;
    localparam logic [2:0] REG_NEAR     = 3'd6;

    localparam logic [2:0]  PRELOAD_TICKS = 3'd4;
    localparam logic [2:0]  START_TICKS   = 3'd5;
    localparam logic [2:0]  STOP_PULSE    = 3'd5;
    localparam logic [7:0]  ARRIVE_NEED   = 8'd3;
    localparam logic [23:0] MIN_ACCEL     = 24'd458;
    localparam logic [23:0] DEF_ACCEL     = 24'd1000;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    function automatic logic [23:0] floor_ramp(input logic [23:0] v);
        logic [23:0] t;
        t = (v == '0) ? DEF_ACCEL : v;
        return (t < MIN_ACCEL) ? MIN_ACCEL : t;
    endfunction

    // |a - b| with full signed range, 33 bits
    function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] a);
        return a[31] ? 32'(-33'(a)) : 32'(a);
    endfunction

endpackage

// ===== design/servo_absolute_move_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_absolute_move_sequencer_top
// Absolute point-to-point move sequencer for a servo drive command image.
// ----------------------------------------------------------------------------
// Every accepted item (feedback tick, move request, stop request or alarm
// clear) yields exactly one result item: the drive command image, a busy flag
// and an event code. An item is accepted in every cycle while the output
// stage is free or being drained; the result appears in the output register
// in the cycle after acceptance. Throughput is one item per cycle while the
// receiver does not stall, set by the single pass of compares and counters
// between the sequencer state and the result register. Configuration writes land at once.
// ----------------------------------------------------------------------------
module servo_absolute_move_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data,
    // input items
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_actual_position,
    input  logic signed [31:0] i_actual_speed,
    input  logic [8:0]         i_status_flags,
    input  logic signed [31:0] i_target_position,
    input  logic [23:0]        i_speed_req,
    input  logic [23:0]        i_accel_req,
    input  logic [23:0]        i_decel_req,
    // result items
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_cmd_mode,
    output logic               o_go_pulse,
    output logic               o_halt_pulse,
    output logic signed [31:0] o_position_out,
    output logic [23:0]        o_speed_out,
    output logic [23:0]        o_accel_out,
    output logic [23:0]        o_decel_out,
    output logic               o_busy_res,
    output logic [2:0]         o_event_res
);

    // configuration registers
    logic [19:0] r_band, r_near;
    logic [15:0] r_still, r_nspeed, r_stop_to, r_move_to;
    logic [7:0]  r_sneed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band    <= 20'd500;
            r_still   <= 16'd5;
            r_nspeed  <= 16'd8;
            r_sneed   <= 8'd20;
            r_stop_to <= 16'd300;
            r_move_to <= 16'd6000;
            r_near    <= 20'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                samseq_pkg::REG_BAND:    r_band    <= i_cfg_data;
                samseq_pkg::REG_STILL:   r_still   <= i_cfg_data[15:0];
                samseq_pkg::REG_NSPEED:  r_nspeed  <= i_cfg_data[15:0];
                samseq_pkg::REG_SNEED:   r_sneed   <= i_cfg_data[7:0];
                samseq_pkg::REG_STOP_TO: r_stop_to <= i_cfg_data[15:0];
                samseq_pkg::REG_MOVE_TO: r_move_to <= i_cfg_data[15:0];
                samseq_pkg::REG_NEAR:    r_near    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    samseq_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_pticks, n_pticks;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_arrive, n_arrive, r_stillc, n_stillc;
    logic [31:0] r_last, n_last, r_cmdpos, n_cmdpos;
    logic        r_svalid, n_svalid, r_moving, n_moving, r_stopask, n_stopask;
    logic [23:0] r_hspeed, n_hspeed, r_haccel, n_haccel, r_hdecel, n_hdecel;
    logic [1:0]  r_supp, n_supp;
    logic [2:0]  n_event;

    logic accept;
    assign o_stall = o_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // shared compares
    logic [32:0] d_last, d_cmd, d_tgt;
    logic [15:0] still_lim;
    logic        spd_low;
    assign d_last    = samseq_pkg::abs_diff(i_actual_position, $signed(r_last));
    assign d_cmd     = samseq_pkg::abs_diff(i_actual_position, $signed(r_cmdpos));
    assign d_tgt     = samseq_pkg::abs_diff(i_actual_position, i_target_position);
    assign still_lim = (r_still == '0) ? 16'd1 : r_still;
    assign spd_low   = i_status_flags[1] ||
                       (samseq_pkg::abs32(i_actual_speed) <= 32'(r_nspeed));

    always_comb begin
        logic [7:0]  sc;
        logic [15:0] el;
        logic [2:0]  pt;
        logic        w14, w15;
        logic [1:0]  sp;
        logic [7:0]  ac;
        n_phase = r_phase;   n_pticks = r_pticks; n_elapsed = r_elapsed;
        n_arrive = r_arrive; n_stillc = r_stillc; n_last = r_last;
        n_cmdpos = r_cmdpos; n_svalid = r_svalid; n_moving = r_moving;
        n_stopask = r_stopask; n_hspeed = r_hspeed; n_haccel = r_haccel;
        n_hdecel = r_hdecel; n_supp = r_supp; n_event = samseq_pkg::EV_NONE;
        sc = r_stillc; el = r_elapsed; pt = r_pticks;
        w14 = i_status_flags[4]; w15 = i_status_flags[5];
        sp = r_supp; ac = r_arrive;
        case (i_req_type)
            samseq_pkg::REQ_TICK: begin
                if (r_moving) begin
                    if (r_phase == samseq_pkg::PH_STOP) begin
                        if (!r_svalid) sc = '0;
                        else if (d_last <= 33'(still_lim)) begin
                            if (sc != samseq_pkg::COUNT_MAX) sc = sc + 8'd1;
                        end else sc = '0;
                        n_svalid = 1'b1;
                        n_stillc = sc;
                        n_last   = i_actual_position;
                        if (pt != '0) pt = pt - 3'd1;
                        if (el != samseq_pkg::ELAPSED_MAX) el = el + 16'd1;
                        n_pticks  = pt;
                        n_elapsed = el;
                        if ((sc >= r_sneed && spd_low) || el >= r_stop_to) begin
                            n_event = (sc >= r_sneed && spd_low) ?
                                      samseq_pkg::EV_SETTLED : samseq_pkg::EV_STOP_TO;
                            n_cmdpos = i_actual_position;
                            n_moving = 1'b0; n_stopask = 1'b0;
                            n_phase = samseq_pkg::PH_IDLE; n_pticks = '0;
                            n_elapsed = '0; n_stillc = '0; n_arrive = '0;
                            n_svalid = 1'b0;
                        end
                    end else begin
                        if (pt != '0) pt = pt - 3'd1;
                        n_pticks = pt;
                        if (r_phase == samseq_pkg::PH_PRELOAD) begin
                            if (pt == '0) begin
                                n_phase = samseq_pkg::PH_START;
                                n_pticks = samseq_pkg::START_TICKS;
                            end
                        end else if (r_phase == samseq_pkg::PH_START) begin
                            if (pt == '0) begin
                                n_phase = samseq_pkg::PH_RUN;
                                n_elapsed = '0;
                            end
                        end else if (r_phase == samseq_pkg::PH_RUN && !r_stopask) begin
                            if (!w14) sp[0] = 1'b0;
                            if (!w15) sp[1] = 1'b0;
                            n_supp = sp;
                            if (i_status_flags[2] || i_status_flags[3] ||
                                (w14 && !sp[0]) || (w15 && !sp[1])) begin
                                n_event = samseq_pkg::EV_FAULT;
                                n_phase = samseq_pkg::PH_STOP;
                                n_pticks = samseq_pkg::STOP_PULSE;
                                n_elapsed = '0; n_stillc = '0; n_svalid = 1'b0;
                            end else begin
                                if (el != samseq_pkg::ELAPSED_MAX) el = el + 16'd1;
                                n_elapsed = el;
                                if (d_cmd <= 33'(r_band) &&
                                    (i_status_flags[0] || spd_low)) begin
                                    if (ac != samseq_pkg::COUNT_MAX) ac = ac + 8'd1;
                                end else ac = '0;
                                n_arrive = ac;
                                if (ac >= samseq_pkg::ARRIVE_NEED) begin
                                    n_event = samseq_pkg::EV_ARRIVED;
                                    n_moving = 1'b0; n_stopask = 1'b0;
                                    n_phase = samseq_pkg::PH_IDLE; n_pticks = '0;
                                    n_elapsed = '0; n_stillc = '0; n_arrive = '0;
                                    n_svalid = 1'b0;
                                end else if (el >= r_move_to) begin
                                    n_event = samseq_pkg::EV_MOVE_TO;
                                    n_phase = samseq_pkg::PH_STOP;
                                    n_pticks = samseq_pkg::STOP_PULSE;
                                    n_elapsed = '0; n_stillc = '0; n_svalid = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            samseq_pkg::REQ_MOVE: begin
                if (!(i_status_flags[6] && i_status_flags[7] &&
                      !i_status_flags[8] && !i_status_flags[2])) begin
                    n_event = samseq_pkg::EV_REJECTED;
                end else begin
                    n_supp    = i_status_flags[5:4];
                    n_cmdpos  = i_target_position;
                    n_stopask = 1'b0;
                    n_hspeed  = i_speed_req;
                    n_haccel  = i_accel_req;
                    n_hdecel  = (i_decel_req == '0) ? i_accel_req : i_decel_req;
                    if (d_tgt <= 33'(r_near)) begin
                        n_moving = 1'b0;
                        n_phase  = samseq_pkg::PH_IDLE;
                    end else begin
                        n_moving  = 1'b1;
                        n_phase   = samseq_pkg::PH_PRELOAD;
                        n_pticks  = samseq_pkg::PRELOAD_TICKS;
                        n_elapsed = '0;
                        n_arrive  = '0;
                    end
                end
            end
            samseq_pkg::REQ_STOP: begin
                n_stopask = 1'b1;
                n_cmdpos  = i_actual_position;
                n_moving  = 1'b1;
                n_phase   = samseq_pkg::PH_STOP;
                n_pticks  = samseq_pkg::STOP_PULSE;
                n_elapsed = '0; n_stillc = '0; n_svalid = 1'b0;
            end
            default: begin
                n_moving = 1'b0;
                n_phase  = samseq_pkg::PH_IDLE;
                n_pticks = '0;
                n_cmdpos = i_actual_position;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= samseq_pkg::PH_IDLE; r_pticks <= '0; r_elapsed <= '0;
            r_arrive <= '0; r_stillc <= '0; r_last <= '0; r_svalid <= 1'b0;
            r_cmdpos <= '0; r_hspeed <= '0; r_haccel <= '0; r_hdecel <= '0;
            r_supp <= '0; r_moving <= 1'b0; r_stopask <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase; r_pticks <= n_pticks; r_elapsed <= n_elapsed;
            r_arrive <= n_arrive; r_stillc <= n_stillc; r_last <= n_last;
            r_svalid <= n_svalid; r_cmdpos <= n_cmdpos; r_hspeed <= n_hspeed;
            r_haccel <= n_haccel; r_hdecel <= n_hdecel; r_supp <= n_supp;
            r_moving <= n_moving; r_stopask <= n_stopask;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (accept) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_cmd_mode     <= (n_phase != samseq_pkg::PH_IDLE);
            o_go_pulse     <= (n_phase == samseq_pkg::PH_START) && (n_pticks != '0);
            o_halt_pulse   <= (n_phase == samseq_pkg::PH_STOP) && (n_pticks != '0);
            o_position_out <= n_cmdpos;
            o_speed_out    <= (n_hspeed == '0) ? 24'd1 : n_hspeed;
            o_accel_out    <= samseq_pkg::floor_ramp(n_haccel);
            o_decel_out    <= samseq_pkg::floor_ramp(n_hdecel);
            o_busy_res     <= n_moving;
            o_event_res    <= n_event;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for servo_absolute_move_sequencer_top
// Drives directed and random request/feedback items with random idling on
// both channels, predicts each command image in a local model of the
// sequencer and compares every result item field by field.
// ----------------------------------------------------------------------------
module tb;

    // one expected command image
    typedef struct packed {
        logic        cmd_mode;
        logic        go_pulse;
        logic        halt_pulse;
        logic [31:0] position_out;
        logic [23:0] speed_out;
        logic [23:0] accel_out;
        logic [23:0] decel_out;
        logic        busy_res;
        logic [2:0]  event_res;
    } t_image;

    // stimulus row: fields of one item plus an optional typed-in expectation
    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] pos;
        logic signed [31:0] spd;
        logic [8:0]         flags;
        logic signed [31:0] tgt;
        logic [23:0]        sreq;
        logic [23:0]        areq;
        logic [23:0]        dreq;
        bit                 has_exp;
        t_image             exp;
    } t_row;

    // flag bits
    localparam int F_ATREF = 0, F_STOPPED = 1, F_LIMIT = 2, F_FAULT = 3;
    localparam int F_A014 = 4, F_A015 = 5, F_ACTIVE = 6, F_READY = 7, F_LINK = 8;
    localparam logic [8:0] OK_FLAGS = 9'h0C0;   // active and ready

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [19:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = '0;
    logic signed [31:0] act_pos = '0;
    logic signed [31:0] act_spd = '0;
    logic [8:0]         flags = '0;
    logic signed [31:0] tgt_pos = '0;
    logic [23:0]        speed_req = '0;
    logic [23:0]        accel_req = '0;
    logic [23:0]        decel_req = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               o_cmd_mode, o_go_pulse, o_halt_pulse, o_busy_res;
    logic signed [31:0] o_position_out;
    logic [23:0]        o_speed_out, o_accel_out, o_decel_out;
    logic [2:0]         o_event_res;

    servo_absolute_move_sequencer_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_req_type(req_type), .i_actual_position(act_pos),
        .i_actual_speed(act_spd), .i_status_flags(flags),
        .i_target_position(tgt_pos), .i_speed_req(speed_req),
        .i_accel_req(accel_req), .i_decel_req(decel_req),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_cmd_mode(o_cmd_mode), .o_go_pulse(o_go_pulse),
        .o_halt_pulse(o_halt_pulse), .o_position_out(o_position_out),
        .o_speed_out(o_speed_out), .o_accel_out(o_accel_out),
        .o_decel_out(o_decel_out), .o_busy_res(o_busy_res),
        .o_event_res(o_event_res)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // ---------------- sequencer prediction ----------------
    // register copies
    logic [19:0] band_puu, near_puu;
    logic [15:0] still_step, nstop_speed, stop_to, move_to;
    logic [7:0]  stable_need;
    // state copies
    samseq_pkg::t_phase seq_phase;
    logic [2:0]  seq_ticks;
    logic [15:0] seq_elapsed;
    logic [7:0]  seq_arrive, seq_still;
    logic [31:0] seq_last, seq_cmd_pos;
    logic        seq_sample_ok, seq_moving, seq_stop_asked;
    logic [23:0] seq_speed, seq_accel, seq_decel;
    logic [1:0]  seq_suppress;

    t_image      image_queue[$];
    int          n_fail = 0;
    bit          quiet = 1'b0;        // no idling in the last part
    bit          hold_rx = 1'b0;      // long receiver hold-off request

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [23:0] ramp_floor(logic [23:0] v);
        logic [23:0] t;
        t = (v == 0) ? 24'd1000 : v;
        return (t < 24'd458) ? 24'd458 : t;
    endfunction

    task automatic model_reset();
        band_puu = 20'd500; still_step = 16'd5; nstop_speed = 16'd8;
        stable_need = 8'd20; stop_to = 16'd300; move_to = 16'd6000;
        near_puu = 20'd50;
        seq_phase = samseq_pkg::PH_IDLE; seq_ticks = 0; seq_elapsed = 0;
        seq_arrive = 0; seq_still = 0; seq_last = 0; seq_sample_ok = 0;
        seq_cmd_pos = 0; seq_speed = 0; seq_accel = 0; seq_decel = 0;
        seq_suppress = 0; seq_moving = 0; seq_stop_asked = 0;
    endtask

    task automatic model_write(logic [2:0] idx, logic [19:0] v);
        case (idx)
            samseq_pkg::REG_BAND:    band_puu = v;
            samseq_pkg::REG_STILL:   still_step = v[15:0];
            samseq_pkg::REG_NSPEED:  nstop_speed = v[15:0];
            samseq_pkg::REG_SNEED:   stable_need = v[7:0];
            samseq_pkg::REG_STOP_TO: stop_to = v[15:0];
            samseq_pkg::REG_MOVE_TO: move_to = v[15:0];
            samseq_pkg::REG_NEAR:    near_puu = v;
            default: ;
        endcase
    endtask

    function automatic void enter_hold();
        seq_moving = 0; seq_stop_asked = 0; seq_phase = samseq_pkg::PH_IDLE;
        seq_ticks = 0; seq_elapsed = 0; seq_still = 0; seq_arrive = 0;
        seq_sample_ok = 0;
    endfunction

    function automatic void enter_stop();
        seq_phase = samseq_pkg::PH_STOP; seq_ticks = samseq_pkg::STOP_PULSE;
        seq_elapsed = 0; seq_still = 0; seq_sample_ok = 0;
    endfunction

    function automatic logic bool_low(logic [8:0] f, longint s);
        return f[F_STOPPED] || mag64(s) <= longint'(nstop_speed);
    endfunction

    function automatic logic [2:0] advance_tick(longint p, longint s, logic [8:0] f);
        longint lim;
        bit     in_band;
        lim = (still_step == 0) ? 1 : longint'(still_step);
        if (seq_phase == samseq_pkg::PH_STOP) begin
            if (!seq_sample_ok) begin
                seq_sample_ok = 1; seq_still = 0;
            end else if (mag64(p - longint'($signed(seq_last))) <= lim) begin
                if (seq_still < 8'd255) seq_still++;
            end else begin
                seq_still = 0;
            end
            seq_last = p[31:0];
            if (seq_ticks > 0) seq_ticks--;
            if (seq_elapsed < 16'hFFFF) seq_elapsed++;
            if (seq_still >= stable_need && bool_low(f, s)) begin
                seq_cmd_pos = p[31:0]; enter_hold(); return samseq_pkg::EV_SETTLED;
            end
            if (seq_elapsed >= stop_to) begin
                seq_cmd_pos = p[31:0]; enter_hold(); return samseq_pkg::EV_STOP_TO;
            end
            return samseq_pkg::EV_NONE;
        end
        if (seq_ticks > 0) seq_ticks--;
        if (seq_phase == samseq_pkg::PH_PRELOAD) begin
            if (seq_ticks == 0) begin
                seq_phase = samseq_pkg::PH_START; seq_ticks = samseq_pkg::START_TICKS;
            end
            return samseq_pkg::EV_NONE;
        end
        if (seq_phase == samseq_pkg::PH_START) begin
            if (seq_ticks == 0) begin
                seq_phase = samseq_pkg::PH_RUN; seq_elapsed = 0;
            end
            return samseq_pkg::EV_NONE;
        end
        if (seq_phase == samseq_pkg::PH_RUN && !seq_stop_asked) begin
            if (!f[F_A014]) seq_suppress[0] = 0;
            if (!f[F_A015]) seq_suppress[1] = 0;
            if (f[F_LIMIT] || f[F_FAULT] || (f[F_A014] && !seq_suppress[0]) ||
                (f[F_A015] && !seq_suppress[1])) begin
                enter_stop(); return samseq_pkg::EV_FAULT;
            end
            if (seq_elapsed < 16'hFFFF) seq_elapsed++;
            in_band = mag64(p - longint'($signed(seq_cmd_pos))) <= longint'(band_puu);
            if (in_band && (f[F_ATREF] || bool_low(f, s))) begin
                if (seq_arrive < 8'd255) seq_arrive++;
                if (seq_arrive >= 8'(samseq_pkg::ARRIVE_NEED)) begin
                    enter_hold(); return samseq_pkg::EV_ARRIVED;
                end
            end else begin
                seq_arrive = 0;
            end
            if (seq_elapsed >= move_to) begin
                enter_stop(); return samseq_pkg::EV_MOVE_TO;
            end
        end
        return samseq_pkg::EV_NONE;
    endfunction

    // apply one item to the model and return the resulting image
    function automatic t_image predict_image(t_row r);
        t_image     im;
        logic [2:0] ev;
        longint     p, s, t;
        p = longint'(r.pos); s = longint'(r.spd); t = longint'(r.tgt);
        ev = samseq_pkg::EV_NONE;
        case (r.req)
            samseq_pkg::REQ_TICK: begin
                if (seq_moving) ev = advance_tick(p, s, r.flags);
            end
            samseq_pkg::REQ_MOVE: begin
                if (!(r.flags[F_ACTIVE] && r.flags[F_READY] && !r.flags[F_LINK] &&
                      !r.flags[F_LIMIT])) begin
                    ev = samseq_pkg::EV_REJECTED;
                end else begin
                    seq_suppress = r.flags[F_A015:F_A014];
                    seq_cmd_pos = r.tgt; seq_stop_asked = 0;
                    seq_speed = r.sreq; seq_accel = r.areq;
                    seq_decel = (r.dreq != 0) ? r.dreq : r.areq;
                    if (mag64(p - t) <= longint'(near_puu)) begin
                        seq_moving = 0; seq_phase = samseq_pkg::PH_IDLE;
                    end else begin
                        seq_moving = 1; seq_phase = samseq_pkg::PH_PRELOAD;
                        seq_ticks = samseq_pkg::PRELOAD_TICKS; seq_elapsed = 0;
                        seq_arrive = 0;
                    end
                end
            end
            samseq_pkg::REQ_STOP: begin
                seq_stop_asked = 1; seq_cmd_pos = r.pos; seq_moving = 1;
                enter_stop();
            end
            default: begin
                seq_moving = 0; seq_phase = samseq_pkg::PH_IDLE; seq_ticks = 0;
                seq_cmd_pos = r.pos;
            end
        endcase
        im.cmd_mode     = (seq_phase != samseq_pkg::PH_IDLE);
        im.go_pulse     = (seq_phase == samseq_pkg::PH_START) && (seq_ticks != 0);
        im.halt_pulse   = (seq_phase == samseq_pkg::PH_STOP) && (seq_ticks != 0);
        im.position_out = seq_cmd_pos;
        im.speed_out    = (seq_speed != 0) ? seq_speed : 24'd1;
        im.accel_out    = ramp_floor(seq_accel);
        im.decel_out    = ramp_floor(seq_decel);
        im.busy_res     = seq_moving;
        im.event_res    = ev;
        return im;
    endfunction

    // ---------------- result checking ----------------
    always @(posedge clk) begin
        t_image e;
        if (rst_n && out_valid && !out_stall) begin
            if (image_queue.size() == 0) begin
                $error("result item with nothing expected");
                n_fail++;
            end else begin
                e = image_queue.pop_front();
                if (o_cmd_mode !== e.cmd_mode) begin
                    $error("cmd_mode exp %0d got %0d", e.cmd_mode, o_cmd_mode); n_fail++;
                end
                if (o_go_pulse !== e.go_pulse) begin
                    $error("go_pulse exp %0d got %0d", e.go_pulse, o_go_pulse);
                    n_fail++;
                end
                if (o_halt_pulse !== e.halt_pulse) begin
                    $error("halt_pulse exp %0d got %0d", e.halt_pulse, o_halt_pulse);
                    n_fail++;
                end
                if (o_position_out !== $signed(e.position_out)) begin
                    $error("position_out exp %0d got %0d", $signed(e.position_out),
                           o_position_out);
                    n_fail++;
                end
                if (o_speed_out !== e.speed_out) begin
                    $error("speed_out exp %0d got %0d", e.speed_out, o_speed_out); n_fail++;
                end
                if (o_accel_out !== e.accel_out) begin
                    $error("accel_out exp %0d got %0d", e.accel_out, o_accel_out); n_fail++;
                end
                if (o_decel_out !== e.decel_out) begin
                    $error("decel_out exp %0d got %0d", e.decel_out, o_decel_out); n_fail++;
                end
                if (o_busy_res !== e.busy_res) begin
                    $error("busy_res exp %0d got %0d", e.busy_res, o_busy_res); n_fail++;
                end
                if (o_event_res !== e.event_res) begin
                    $error("event_res exp %0d got %0d", e.event_res, o_event_res); n_fail++;
                end
            end
        end
    end

    // ---------------- receiver stall ----------------
    // Random bursts of stall, a long hold-off on request, none when quiet.
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (hold_rx) begin
                out_stall <= 1'b1;
                repeat (150) @(negedge clk);
                hold_rx = 1'b0;
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
                // release at the next falling edge of the loop
                @(negedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------- driving ----------------
    // Offer one item at the falling edge and hold it until it is accepted.
    task automatic send_item(t_row r);
        t_image im;
        int     gap;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type <= r.req; act_pos <= r.pos; act_spd <= r.spd; flags <= r.flags;
        tgt_pos <= r.tgt; speed_req <= r.sreq; accel_req <= r.areq;
        decel_req <= r.dreq; in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        im = predict_image(r);
        if (r.has_exp && im !== r.exp) begin
            $error("typed-in row disagrees with prediction: exp %h pred %h", r.exp, im);
            n_fail++;
        end
        image_queue.push_back(im);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (image_queue.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write enable stays high across a series of writes; the caller drops it
    task automatic write_reg(logic [2:0] idx, logic [19:0] v);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        model_write(idx, v);
    endtask

    function automatic t_row mk(logic [1:0] rq, logic signed [31:0] p,
                                logic signed [31:0] s, logic [8:0] f,
                                logic signed [31:0] t, logic [23:0] sr,
                                logic [23:0] ar, logic [23:0] dr);
        t_row r;
        r.req = rq; r.pos = p; r.spd = s; r.flags = f; r.tgt = t;
        r.sreq = sr; r.areq = ar; r.dreq = dr; r.has_exp = 0; r.exp = '0;
        return r;
    endfunction

    function automatic t_row noise_row();
        return mk(2'($urandom), $urandom, $urandom, 9'($urandom), $urandom,
                  24'($urandom), 24'($urandom), 24'($urandom));
    endfunction

    // One well-formed move: request, feedback that walks to the target, with
    // occasional warnings, faults, stops and clears mixed in.
    task automatic random_move(ref int budget);
        logic signed [31:0] p, t;
        logic [8:0]         f;
        int                 steps, k, mode;
        longint             d;
        p = $urandom_range(0, 3) == 0 ? $signed($urandom) : $signed($urandom_range(0, 20000));
        t = p + $signed($urandom_range(0, 4000)) - 2000;
        f = OK_FLAGS | 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) << F_A014 : 0);
        if ($urandom_range(0, 9) == 0) f = 9'($urandom);
        send_item(mk(samseq_pkg::REQ_MOVE, p, $urandom_range(0, 20), f, t,
                     $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom),
                     $urandom_range(0, 3) == 0 ? 24'($urandom_range(0, 600)) : 24'($urandom),
                     $urandom_range(0, 2) == 0 ? 24'd0 : 24'($urandom)));
        budget--;
        mode = $urandom_range(0, 9);
        steps = $urandom_range(12, 40);
        for (k = 0; k < steps && budget > 0; k++) begin
            d = longint'(t) - longint'(p);
            p = p + 32'(d / 3);
            f = OK_FLAGS | 9'($urandom_range(0, 1));
            if (mode == 0 && $urandom_range(0, 7) == 0) f[F_A014 + $urandom_range(0, 1)] = 1;
            if (mode == 1 && $urandom_range(0, 9) == 0) f[F_LIMIT + $urandom_range(0, 1)] = 1;
            if (mode == 2 && k == 8) begin
                send_item(mk(samseq_pkg::REQ_STOP, p, $urandom_range(0, 50), f,
                             0, 0, 0, 0));
            end else if (mode == 3 && k == 10) begin
                send_item(mk(samseq_pkg::REQ_CLEAR, p, 0, f, 0, 0, 0, 0));
            end else if (mode == 4 && $urandom_range(0, 15) == 0) begin
                send_item(noise_row());
            end else begin
                f[F_STOPPED] = $urandom_range(0, 3) == 0;
                send_item(mk(samseq_pkg::REQ_TICK, p + $signed($urandom_range(0, 6)) - 3,
                             $signed($urandom_range(0, 24)) - 12, f, $urandom, 0, 0, 0));
            end
            budget--;
        end
    endtask

    t_row dir_rows[$];

    initial begin
        t_row r;
        int   budget, i, phase_no;
        model_reset();
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, every request, rejected, near target, zero decel,
        // stop while idle, clear alarm, limit abort, warnings suppressed from the move
        r = mk(samseq_pkg::REQ_TICK, 32'sh7FFFFFFF, 32'sh80000000, 9'h1FF, 0, 0, 0, 0);
        r.has_exp = 1; r.exp = '{0, 0, 0, 0, 1, 1000, 1000, 0, samseq_pkg::EV_NONE};
        dir_rows.push_back(r);
        r = mk(samseq_pkg::REQ_MOVE, 0, 0, 9'h000, 100, 5, 5, 5);          // not ready
        r.has_exp = 1; r.exp = '{0, 0, 0, 0, 1, 1000, 1000, 0, samseq_pkg::EV_REJECTED};
        dir_rows.push_back(r);
        r = mk(samseq_pkg::REQ_MOVE, 0, 0, 9'h1FF, 100, 5, 5, 5);          // link fault
        r.has_exp = 1; r.exp = '{0, 0, 0, 0, 1, 1000, 1000, 0, samseq_pkg::EV_REJECTED};
        dir_rows.push_back(r);
        r = mk(samseq_pkg::REQ_MOVE, 1000, 0, OK_FLAGS, 1050, 24'hFFFFFF, 24'hFFFFFF, 0);
        r.has_exp = 1;                                          // near target, hold
        r.exp = '{0, 0, 0, 1050, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0,
                  samseq_pkg::EV_NONE};
        dir_rows.push_back(r);
        dir_rows.push_back(mk(samseq_pkg::REQ_MOVE, 32'sh80000000, 0, OK_FLAGS | 9'h030,
                              32'sh7FFFFFFF, 0, 1, 0));
        for (i = 0; i < 9; i++)
            dir_rows.push_back(mk(samseq_pkg::REQ_TICK, 32'sh80000000, 0,
                                  OK_FLAGS | 9'h030, 0, 0, 0, 0));
        dir_rows.push_back(mk(samseq_pkg::REQ_TICK, 0, 0, OK_FLAGS | 9'h004,
                              0, 0, 0, 0));  // limit
        dir_rows.push_back(mk(samseq_pkg::REQ_TICK, 0, 0, OK_FLAGS, 0, 0, 0, 0));
        r = mk(samseq_pkg::REQ_CLEAR, -7, 0, 0, 0, 0, 0, 0);
        r.has_exp = 1; r.exp = '{0, 0, 0, -7, 1, 458, 458, 0, samseq_pkg::EV_NONE};
        dir_rows.push_back(r);
        r = mk(samseq_pkg::REQ_STOP, 42, 0, 0, 0, 0, 0, 0);      // stop while idle
        r.has_exp = 1; r.exp = '{1, 0, 1, 42, 1, 458, 458, 1, samseq_pkg::EV_NONE};
        dir_rows.push_back(r);
        for (i = 0; i < 5; i++)
            dir_rows.push_back(mk(samseq_pkg::REQ_TICK, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                  0, 0, 0, 0, 0));
        dir_rows.push_back(mk(samseq_pkg::REQ_MOVE, 0, 0, OK_FLAGS, 30000, 1, 457, 459));
        dir_rows.push_back(mk(samseq_pkg::REQ_TICK, 5, 0, 9'h000, 0, 0, 0, 0));
        foreach (dir_rows[k]) send_item(dir_rows[k]);
        drain();
        repeat (4) @(negedge clk);

        // random phases, each with its own register setting
        for (phase_no = 0; phase_no < 5; phase_no++) begin
            case (phase_no)
                0: begin
                    write_reg(samseq_pkg::REG_BAND, 0);
                    write_reg(samseq_pkg::REG_STILL, 1);
                    write_reg(samseq_pkg::REG_NSPEED, 0);
                    write_reg(samseq_pkg::REG_SNEED, 1);
                    write_reg(samseq_pkg::REG_STOP_TO, 1);
                    write_reg(samseq_pkg::REG_MOVE_TO, 1);
                    write_reg(samseq_pkg::REG_NEAR, 0);
                end
                1: begin
                    write_reg(samseq_pkg::REG_BAND, 20'hFFFFF);
                    write_reg(samseq_pkg::REG_STILL, 16'hFFFF);
                    write_reg(samseq_pkg::REG_NSPEED, 16'hFFFF);
                    write_reg(samseq_pkg::REG_SNEED, 8'hFF);
                    write_reg(samseq_pkg::REG_STOP_TO, 16'hFFFF);
                    write_reg(samseq_pkg::REG_MOVE_TO, 16'hFFFF);
                    write_reg(samseq_pkg::REG_NEAR, 20'hFFFFF);
                end
                2: begin
                    write_reg(samseq_pkg::REG_STILL, 0);   // zero acts as one
                    write_reg(samseq_pkg::REG_NEAR, 20);
                    write_reg(samseq_pkg::REG_BAND, 30);
                    write_reg(samseq_pkg::REG_SNEED, 3);
                    write_reg(samseq_pkg::REG_STOP_TO, 25);
                    write_reg(samseq_pkg::REG_MOVE_TO, 30);
                    write_reg(samseq_pkg::REG_NSPEED, 6);
                end
                default: begin
                    write_reg(samseq_pkg::REG_BAND, $urandom_range(0, 800));
                    write_reg(samseq_pkg::REG_STILL, $urandom_range(1, 10));
                    write_reg(samseq_pkg::REG_NSPEED, $urandom_range(0, 15));
                    write_reg(samseq_pkg::REG_SNEED, $urandom_range(1, 8));
                    write_reg(samseq_pkg::REG_STOP_TO, $urandom_range(5, 60));
                    write_reg(samseq_pkg::REG_MOVE_TO, $urandom_range(10, 80));
                    write_reg(samseq_pkg::REG_NEAR, $urandom_range(0, 100));
                end
            endcase
            cfg_we <= 1'b0;
            if (phase_no == 4) quiet = 1'b1;
            if (phase_no == 1) hold_rx = 1'b1;   // fill up and back-pressure
            budget = 210;
            while (budget > 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_item(noise_row());
                    budget--;
                end else begin
                    random_move(budget);
                end
                if (phase_no == 3 && budget < 100 && budget > 90) begin
                    // sender waits for every result
                    in_valid <= 1'b0;
                    while (image_queue.size() != 0) @(negedge clk);
                end
            end
            drain();
        end
        repeat (10) @(negedge clk);
        if (n_fail == 0 && image_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
design/samseq_pkg.sv
design/servo_absolute_move_sequencer_top.sv
verif/tb.sv
